@@ src/reorder_receiver_cumulative_ack_macros.svh @@
// ----------------------------------------------------------------------------
// reorder receiver assertion macros
// Concurrent assertion wrappers shared by the reorder receiver modules.
// ----------------------------------------------------------------------------
`ifndef REORDER_RECEIVER_CUMULATIVE_ACK_MACROS_SVH
`define REORDER_RECEIVER_CUMULATIVE_ACK_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked every cycle outside reset
`define RRCA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rrca assertion failed");

// antecedent in one cycle implies consequent in the next
`define RRCA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrca sequence assertion failed");

`else

`define RRCA_ASSERT(lbl, clk, rst, prop)
`define RRCA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/rrca_pkg.sv @@
// ----------------------------------------------------------------------------
// rrca_pkg
// Types, codes and constants shared by the reorder receiver modules.
// ----------------------------------------------------------------------------
package rrca_pkg;

   localparam int DEF_PEER_COUNT = 8;
   localparam int DEF_SEQ_SLOTS  = 512;

   // bitmap word geometry
   localparam int WORD_W     = 16;
   localparam int WORD_SHIFT = 4;

   // command queue, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] VERDICT_INORDER = 2'd0;
   localparam logic [1:0] VERDICT_DUP     = 2'd1;
   localparam logic [1:0] VERDICT_STALE   = 2'd2;
   localparam logic [1:0] VERDICT_RANGE   = 2'd3;

   typedef struct packed {
      logic [2:0]  peer;
      logic [11:0] seq_id;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       send_ack;
      logic [8:0] ack_value;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_PEER_RANGE,
      CMD_SEQ_RANGE,
      CMD_RECORD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   peer;
      logic [11:0]  seq_id;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_RESULT
   } back_state_type;

endpackage

@@ src/rrca_front.sv @@
// ----------------------------------------------------------------------------
// rrca_front
// Accepts packets and classifies them by peer and sequence range.
// ----------------------------------------------------------------------------
module rrca_front
   import rrca_pkg::*;
#(
   parameter int PEER_COUNT = DEF_PEER_COUNT,
   parameter int SEQ_SLOTS  = DEF_SEQ_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    clearing,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_data
);

   logic peer_bad;
   logic seq_bad;

   assign peer_bad = int'(req_payload.peer) >= PEER_COUNT;
   assign seq_bad  = int'(req_payload.seq_id) >= SEQ_SLOTS;

   // nothing enters while the bitmap is being cleared
   assign req_ready  = push_ready && !clearing;
   assign push_valid = req_valid && !clearing;

   always_comb begin
      push_data.peer   = req_payload.peer;
      push_data.seq_id = req_payload.seq_id;
      if (peer_bad) begin
         push_data.kind = CMD_PEER_RANGE;
      end else if (seq_bad) begin
         push_data.kind = CMD_SEQ_RANGE;
      end else begin
         push_data.kind = CMD_RECORD;
      end
   end

   `include "reorder_receiver_cumulative_ack_macros.svh"

   `RRCA_ASSERT(a_front_no_push_clearing, clock, reset, !(clearing && push_valid))

endmodule

@@ src/rrca_queue.sv @@
// ----------------------------------------------------------------------------
// rrca_queue
// Short command queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
`include "reorder_receiver_cumulative_ack_macros.svh"

module rrca_queue
   import rrca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RRCA_ASSERT(a_queue_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `RRCA_ASSERT(a_queue_ptr_match, clock, reset, (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) == (wr_ptr_ff == rd_ptr_ff))
   `RRCA_ASSERT_NEXT(a_queue_grow, clock, reset, push_fire && !pop_fire, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ src/rrca_back.sv @@
// ----------------------------------------------------------------------------
// rrca_back
// Bitmap update, next-expected scan and result register of the receiver.
// ----------------------------------------------------------------------------
`include "reorder_receiver_cumulative_ack_macros.svh"

module rrca_back
   import rrca_pkg::*;
#(
   parameter int PEER_COUNT = DEF_PEER_COUNT,
   parameter int SEQ_SLOTS  = DEF_SEQ_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    clearing,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int PEER_W    = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;
   localparam int NE_W      = $clog2(SEQ_SLOTS + 1);
   localparam int WIDX_W    = NE_W - WORD_SHIFT;
   localparam int WPP       = (SEQ_SLOTS + WORD_W - 1) / WORD_W;
   localparam int MEM_DEPTH = PEER_COUNT * WPP;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   back_state_type      state_ff;
   back_state_type      state_in;
   cmd_type             cur_ff;
   cmd_type             cur_in;
   logic [NE_W-1:0]     pos_ff;
   logic [NE_W-1:0]     pos_in;
   rsp_type             res_ff;
   rsp_type             res_in;
   logic [MEM_AW-1:0]   clr_addr_ff;
   logic [MEM_AW-1:0]   clr_addr_in;
   logic [PEER_COUNT-1:0] conn_open_ff;
   logic [PEER_COUNT-1:0] conn_open_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;

   logic [WORD_W-1:0]   bitmap_mem [MEM_DEPTH];
   logic [WORD_W-1:0]   bm_rdata_ff;
   logic                bm_re;
   logic [MEM_AW-1:0]   bm_raddr;
   logic                bm_we;
   logic [MEM_AW-1:0]   bm_waddr;
   logic [WORD_W-1:0]   bm_wdata;

   logic [NE_W-1:0]     ne_mem [PEER_COUNT];
   logic [NE_W-1:0]     ne_rd_ff;
   logic                open_rd_ff;
   logic                ne_re;
   logic                ne_we;
   logic [PEER_W-1:0]   ne_waddr;
   logic [NE_W-1:0]     ne_wdata;

   logic [PEER_W-1:0]   cmd_peer;
   logic [NE_W-1:0]     cmd_pos;
   logic [PEER_W-1:0]   cur_peer;
   logic [WIDX_W-1:0]   cur_widx;
   logic [NE_W-1:0]     ne_eff;
   logic [WORD_W-1:0]   free_bits;
   logic                free_any;
   logic [WORD_SHIFT-1:0] free_idx;
   logic [NE_W-1:0]     found_pos;
   logic                out_load;

   function automatic logic [MEM_AW-1:0] word_addr(input logic [PEER_W-1:0] p,
                                                   input logic [WIDX_W-1:0] w);
      return MEM_AW'(p) * MEM_AW'(WPP) + MEM_AW'(w);
   endfunction

   assign cmd_peer = PEER_W'(cmd_data.peer);
   assign cmd_pos  = NE_W'(cmd_data.seq_id);
   assign cur_peer = PEER_W'(cur_ff.peer);
   assign cur_widx = pos_ff[NE_W-1:WORD_SHIFT];
   // a peer never opened reads as next expected one
   assign ne_eff   = open_rd_ff ? ne_rd_ff : NE_W'(1);
   assign clearing = state_ff == ST_CLEAR;

   // first missing sequence at or above the scan position in this word
   always_comb begin
      free_bits = ~bm_rdata_ff & ({WORD_W{1'b1}} << pos_ff[WORD_SHIFT-1:0]);
      free_any  = free_bits != '0;
      free_idx  = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_idx = WORD_SHIFT'(i);
         end
      end
      found_pos = {cur_widx, free_idx};
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      clr_addr_in  = clr_addr_ff;
      conn_open_in = conn_open_ff;
      cmd_ready    = 1'b0;
      bm_re        = 1'b0;
      bm_raddr     = '0;
      bm_we        = 1'b0;
      bm_waddr     = '0;
      bm_wdata     = '0;
      ne_re        = 1'b0;
      ne_we        = 1'b0;
      ne_waddr     = '0;
      ne_wdata     = '0;
      out_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            bm_we       = 1'b1;
            bm_waddr    = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == MEM_AW'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in           = cmd_data;
               pos_in           = cmd_pos;
               ne_re            = 1'b1;
               res_in.verdict   = VERDICT_RANGE;
               res_in.send_ack  = 1'b0;
               res_in.ack_value = '0;
               state_in         = ST_RESULT;
               if (cmd_data.kind != CMD_PEER_RANGE) begin
                  // first packet opens the connection
                  if (!conn_open_ff[cmd_peer]) begin
                     conn_open_in[cmd_peer] = 1'b1;
                     ne_we    = 1'b1;
                     ne_waddr = cmd_peer;
                     ne_wdata = NE_W'(1);
                  end
               end
               if (cmd_data.kind == CMD_RECORD) begin
                  bm_re    = 1'b1;
                  bm_raddr = word_addr(cmd_peer, cmd_pos[NE_W-1:WORD_SHIFT]);
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            bm_we    = 1'b1;
            bm_waddr = word_addr(cur_peer, cur_widx);
            bm_wdata = bm_rdata_ff | (WORD_W'(1) << pos_ff[WORD_SHIFT-1:0]);
            if (pos_ff == ne_eff) begin
               state_in = ST_SCAN_RD;
            end else if (pos_ff > ne_eff) begin
               res_in.verdict   = VERDICT_DUP;
               res_in.send_ack  = 1'b1;
               res_in.ack_value = 9'(ne_eff - 1'b1);
               state_in         = ST_RESULT;
            end else begin
               res_in.verdict   = VERDICT_STALE;
               res_in.send_ack  = 1'b0;
               res_in.ack_value = '0;
               state_in         = ST_RESULT;
            end
         end
         ST_SCAN_RD: begin
            bm_re    = 1'b1;
            bm_raddr = word_addr(cur_peer, cur_widx);
            state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (free_any || cur_widx == WIDX_W'(WPP - 1)) begin
               ne_we    = 1'b1;
               ne_waddr = cur_peer;
               // the scan stops at the buffer end
               if (!free_any || found_pos > NE_W'(SEQ_SLOTS)) begin
                  ne_wdata = NE_W'(SEQ_SLOTS);
               end else begin
                  ne_wdata = found_pos;
               end
               res_in.verdict   = VERDICT_INORDER;
               res_in.send_ack  = 1'b1;
               res_in.ack_value = 9'(ne_wdata - 1'b1);
               state_in         = ST_RESULT;
            end else begin
               pos_in   = {cur_widx + 1'b1, {WORD_SHIFT{1'b0}}};
               state_in = ST_SCAN_RD;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         conn_open_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         conn_open_ff <= conn_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      res_ff <= res_in;
      if (out_load) begin
         rsp_ff <= res_ff;
      end
   end

   // received bitmap, one word per sixteen sequence numbers
   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_re) begin
         bm_rdata_ff <= bitmap_mem[bm_raddr];
      end
   end

   // next expected table, entries valid once the peer is open
   always_ff @(posedge clock) begin
      if (ne_we) begin
         ne_mem[ne_waddr] <= ne_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ne_re) begin
         ne_rd_ff   <= ne_mem[cmd_peer];
         open_rd_ff <= conn_open_ff[cmd_peer];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RRCA_ASSERT(a_back_ne_in_range, clock, reset, !ne_we || (ne_wdata != '0 && ne_wdata <= NE_W'(SEQ_SLOTS)))
   `RRCA_ASSERT(a_back_no_ack_zero, clock, reset, !(state_ff == ST_RESULT && !res_ff.send_ack) || res_ff.ack_value == '0)
   `RRCA_ASSERT_NEXT(a_back_eval_after_read, clock, reset, state_ff == ST_SCAN_RD, state_ff == ST_SCAN_EVAL)
   `RRCA_ASSERT_NEXT(a_back_mark_after_pop, clock, reset, cmd_valid && cmd_ready && cmd_data.kind == CMD_RECORD, state_ff == ST_MARK)

endmodule

@@ src/reorder_receiver_cumulative_ack.sv @@
// ----------------------------------------------------------------------------
// reorder_receiver_cumulative_ack
// Per-peer receive window tracking with cumulative and duplicate ACKs.
// ----------------------------------------------------------------------------
// Each packet gives one result. A front end classifies the packet and puts it
// in a two-entry command queue; the back end works on one command at a time.
// Range errors pass through queue pop and result in the back end; stale or
// duplicate packets through queue pop, bitmap read and mark, and result. An
// in-order packet adds a read and an evaluation of every sixteen-bit bitmap
// word the next-expected scan walks through, at most ceil(SEQ_SLOTS/16)
// words in all, before its result.
// After reset a clearing pass zeroes the bitmap, one word a cycle, covering
// PEER_COUNT * ceil(SEQ_SLOTS/16) words (256 with the default sizes), and no
// packet is taken until it ends.
module reorder_receiver_cumulative_ack
   import rrca_pkg::*;
#(
   parameter int PEER_COUNT = DEF_PEER_COUNT,
   parameter int SEQ_SLOTS  = DEF_SEQ_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    clearing;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   rrca_front #(
      .PEER_COUNT (PEER_COUNT),
      .SEQ_SLOTS  (SEQ_SLOTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .clearing    (clearing),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   rrca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rrca_back #(
      .PEER_COUNT (PEER_COUNT),
      .SEQ_SLOTS  (SEQ_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd_data    (pop_data),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ dv/reorder_receiver_cumulative_ack_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_receiver_cumulative_ack_tb
// Self-checking bench for the per-peer receive window. A window tracker
// mirrors the bitmap and next-expected number of every peer and predicts the
// verdict and ack for each packet; accepted results are compared in order.
// A directed set opens with the edge cases, then random traffic sweeps one
// peer through its whole window to the buffer end, mixed with near-window,
// stale, out-of-range and fully random packets on all peers.
// ----------------------------------------------------------------------------
module reorder_receiver_cumulative_ack_tb;
   import rrca_pkg::*;

   localparam int PEER_COUNT   = DEF_PEER_COUNT;
   localparam int SEQ_SLOTS    = DEF_SEQ_SLOTS;
   localparam int RANDOM_ITEMS = 780;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 120;

   class ack_window;
      bit              conn_open[PEER_COUNT];
      int unsigned     next_expected[PEER_COUNT];
      bit              received[PEER_COUNT][SEQ_SLOTS];
      rsp_type         pending_acks[$];
      int              errors;
      int              tally[4];

      function new();
         foreach (next_expected[i]) next_expected[i] = 1;
      endfunction

      function void note_packet(req_type pkt);
         rsp_type     r;
         int unsigned pk;
         int unsigned s;
         int unsigned ne;
         pk = pkt.peer;
         s  = pkt.seq_id;
         r  = '0;
         r.verdict = VERDICT_RANGE;
         if (pk < PEER_COUNT) begin
            if (!conn_open[pk]) begin
               conn_open[pk]     = 1'b1;
               next_expected[pk] = 1;
            end
            if (s < SEQ_SLOTS) begin
               received[pk][s] = 1'b1;
               ne = next_expected[pk];
               if (s == ne) begin
                  // walk past everything already held, never beyond the buffer
                  while (ne < SEQ_SLOTS && received[pk][ne]) ne++;
                  next_expected[pk] = ne;
                  r.verdict   = VERDICT_INORDER;
                  r.send_ack  = 1'b1;
                  r.ack_value = 9'(ne - 1);
               end else if (s > ne) begin
                  r.verdict   = VERDICT_DUP;
                  r.send_ack  = 1'b1;
                  r.ack_value = 9'(ne - 1);
               end else begin
                  r.verdict = VERDICT_STALE;
               end
            end
         end
         tally[r.verdict]++;
         pending_acks.push_back(r);
      endfunction

      function void check_ack(rsp_type got);
         rsp_type want;
         if (pending_acks.size() == 0) begin
            $error("result with nothing expected: verdict %0d send_ack %0d ack_value %0d",
                   got.verdict, got.send_ack, got.ack_value);
            errors++;
            return;
         end
         want = pending_acks.pop_front();
         if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
            errors++;
         end
         if (got.send_ack !== want.send_ack) begin
            $error("send_ack: expected %0d, actual %0d", want.send_ack, got.send_ack);
            errors++;
         end
         if (got.ack_value !== want.ack_value) begin
            $error("ack_value: expected %0d, actual %0d", want.ack_value, got.ack_value);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   ack_window   tracker = new();
   bit          no_idle = 1'b0;
   int          rsp_wait = 0;
   int unsigned cycle_count = 0;

   reorder_receiver_cumulative_ack u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   // one packet transfer, with a random lead-in gap
   task automatic drive_packet(input logic [2:0] peer, input logic [11:0] seq);
      int g;
      g = draw_gap();
      @(negedge clock);
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_payload.peer   = peer;
      req_payload.seq_id = seq;
      do @(posedge clock); while (!req_ready);
      tracker.note_packet(req_payload);
   endtask

   task automatic wait_for_acks();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending_acks.size() != 0) @(posedge clock);
   endtask

   // result side: ready held low for a drawn number of cycles after each transfer
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_ready = 1'b0;
         rsp_wait--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_ack(rsp_payload);
         rsp_wait = draw_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("reorder_receiver_cumulative_ack test failed");
         $finish;
      end
   end

   initial begin
      int unsigned order[$];
      int unsigned sweep_peer;
      int unsigned pk;
      int unsigned ne;
      int unsigned sel;
      int          n;
      int          j;
      int          k;
      int          m;
      int          r;
      int          blk_base;
      int unsigned tmp;
      logic [11:0] seq;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: stale zero, gap filling across held numbers, duplicates,
      // out-of-range numbers that still open a connection
      drive_packet(3'd0, 12'd0);
      drive_packet(3'd0, 12'd1);
      drive_packet(3'd0, 12'd3);
      drive_packet(3'd0, 12'd5);
      drive_packet(3'd0, 12'd2);
      drive_packet(3'd0, 12'd2);
      drive_packet(3'd0, 12'd4);
      drive_packet(3'd0, 12'd511);
      drive_packet(3'd0, 12'd512);
      drive_packet(3'd0, 12'd4095);
      drive_packet(3'd7, 12'd4095);
      drive_packet(3'd7, 12'd1);
      drive_packet(3'd7, 12'd0);
      drive_packet(3'd3, 12'd511);
      drive_packet(3'd3, 12'd1);
      drive_packet(3'd6, 12'd0);
      drive_packet(3'd5, 12'haaa);
      drive_packet(3'd2, 12'h555);
      drive_packet(3'd1, 12'h0aa);
      drive_packet(3'd4, 12'h155);
      drive_packet(3'd4, 12'd1);
      wait_for_acks();

      // one peer gets every number of its window, shuffled in short blocks
      sweep_peer = $urandom_range(0, PEER_COUNT - 1);
      j = 1;
      while (j < SEQ_SLOTS) begin
         k = $urandom_range(4, 24);
         if (j + k > SEQ_SLOTS) k = SEQ_SLOTS - j;
         blk_base = order.size();
         for (m = 0; m < k; m++) order.push_back(j + m);
         for (m = k - 1; m > 0; m--) begin
            r = $urandom_range(0, m);
            tmp = order[blk_base + m];
            order[blk_base + m] = order[blk_base + r];
            order[blk_base + r] = tmp;
         end
         j += k;
      end

      n = 0;
      while (order.size() > 0 || n < RANDOM_ITEMS) begin
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_for_acks();
         if (order.size() > 0 && $urandom_range(0, 99) < 65) begin
            drive_packet(3'(sweep_peer), 12'(order.pop_front()));
         end else begin
            pk  = $urandom_range(0, PEER_COUNT - 1);
            ne  = tracker.next_expected[pk];
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
               seq = 12'(ne + $urandom_range(0, 6));
            end else if (sel < 65) begin
               seq = 12'($urandom_range(0, 4095));
            end else if (sel < 80) begin
               seq = (ne > 1) ? 12'($urandom_range(0, ne - 1)) : 12'd0;
            end else if (sel < 90) begin
               seq = 12'($urandom_range(SEQ_SLOTS, 4095));
            end else begin
               case ($urandom_range(0, 2))
                  0: seq = 12'd0;
                  1: seq = 12'(SEQ_SLOTS - 1);
                  default: seq = 12'd4095;
               endcase
            end
            drive_packet(3'(pk), seq);
         end
         n++;
      end

      wait_for_acks();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.pending_acks.size() != 0) begin
         $error("%0d results never arrived", tracker.pending_acks.size());
         tracker.errors++;
      end
      $display("%0d packets: %0d in-order, %0d duplicate, %0d stale, %0d out of range",
               tracker.tally[0] + tracker.tally[1] + tracker.tally[2] + tracker.tally[3],
               tracker.tally[VERDICT_INORDER], tracker.tally[VERDICT_DUP],
               tracker.tally[VERDICT_STALE], tracker.tally[VERDICT_RANGE]);
      $display("peer %0d swept its window, next expected now %0d",
               sweep_peer, tracker.next_expected[sweep_peer]);
      if (tracker.errors == 0) begin
         $display("reorder_receiver_cumulative_ack test passed");
      end else begin
         $display("reorder_receiver_cumulative_ack test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/rrca_pkg.sv
src/rrca_front.sv
src/rrca_queue.sv
src/rrca_back.sv
src/reorder_receiver_cumulative_ack.sv
dv/reorder_receiver_cumulative_ack_tb.sv
